// File: rtl/deadline_timer_queue_top_defines.svh
`ifndef DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dtq_pkg.sv
package dtq_pkg;

  localparam int unsigned NUM_TIMERS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 32;

  // field widths at the ports
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned LATE_W  = 33;
  localparam int unsigned PREC_W  = 16;

  // most expiries reported by one elapse request
  localparam int unsigned RES_MAX = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_CANCEL   = 3'd1,
    CMD_RESTART  = 3'd2,
    CMD_ELAPSE   = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_SCAN,
    ST_WRITE,
    ST_POST_SCAN,
    ST_JUDGE,
    ST_ESCAN,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// File: rtl/dtq_ram.sv
module dtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dtq_scan.sv
// Earliest-deadline search: one slot per cycle through a single comparator.
module dtq_scan #(
  parameter int unsigned NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TIME_BITS  = dtq_pkg::TIME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_TIMERS-1:0]         active_i,
  input  logic [TIME_BITS-1:0]          rd_end_i,
  output logic [$clog2(NUM_TIMERS)-1:0] rd_addr_o,
  output dtq_pkg::scan_stat_t           stat_o,
  output logic [$clog2(NUM_TIMERS)-1:0] head_idx_o,
  output logic [TIME_BITS-1:0]          head_end_o
);

  import dtq_pkg::*;

  localparam int unsigned IW = $clog2(NUM_TIMERS);

  logic          busy_q;
  logic          done_q;
  logic [IW:0]   cnt_q;
  logic          cmp_v_q;
  logic [IW-1:0] cmp_idx_q;
  logic          found_q;
  logic [IW-1:0] best_idx_q;
  logic [TIME_BITS-1:0] best_end_q;
  logic          take;
  logic          issue;

  // strict less-than keeps the lowest index on equal deadlines
  assign take  = cmp_v_q && active_i[cmp_idx_q] && (!found_q || (rd_end_i < best_end_q));
  assign issue = busy_q && (cnt_q < (IW+1)'(NUM_TIMERS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      cmp_v_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      done_q  <= 1'b0;
      cmp_v_q <= issue;
      if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_idx_q <= cnt_q[IW-1:0];
    end
    if (take && !start_i) begin
      best_idx_q <= cmp_idx_q;
      best_end_q <= rd_end_i;
    end
  end

  assign rd_addr_o    = cnt_q[IW-1:0];
  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign stat_o.found = found_q;
  assign head_idx_o   = best_idx_q;
  assign head_end_o   = best_end_q;

endmodule

// File: rtl/deadline_timer_queue_top.sv
// Schedule/restart: a head scan, the RAM write, then a second head scan before the result;
//   cancel, clear and unknown commands: two passes of the one-slot-per-cycle deadline
//   scan. Elapse: one head scan, then a rescan after each expiry. Output stalls lengthen all of these.
// Throughput: one request at a time; in_ready_o is high only while idle, and the next request
//   is taken while the last result waits. Reset (rst_ni low, async) empties queue, precision 0.
module deadline_timer_queue_top #(
  parameter int unsigned NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF,
  parameter int unsigned TIME_BITS  = dtq_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: precision register
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dtq_pkg::PREC_W-1:0]  cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dtq_pkg::CMD_W-1:0]   command_i,
  input  logic [dtq_pkg::ID_W-1:0]    timer_id_i,
  input  logic [dtq_pkg::FIELD_W-1:0] period_i,
  input  logic [dtq_pkg::FIELD_W-1:0] time_now_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        expired_valid_o,
  output logic [dtq_pkg::ID_W-1:0]    expired_id_o,
  output logic signed [dtq_pkg::LATE_W-1:0] lateness_o,
  output logic                        head_changed_o,
  output logic                        queue_empty_o,
  output logic [dtq_pkg::FIELD_W-1:0] next_deadline_o,
  output logic                        last_o
);

  import dtq_pkg::*;

  localparam int unsigned IW = $clog2(NUM_TIMERS);
  localparam int unsigned LW = (TIME_BITS > LATE_W) ? TIME_BITS : LATE_W;
  localparam int unsigned NW = $clog2(RES_MAX + 1);

  // Slot times live in a RAM ({start, end} per slot). Active bits and written bits are
  // flops; a slot never written has no defined RAM contents, and restart gives it zero duration.
  // Flow of a request:
  //   PRE_SCAN  find the current head (h0)
  //   WRITE     schedule/restart: store start and saturated end, mark active
  //   POST_SCAN find the new head; STATUS reports it
  //   elapse    JUDGE tests the head against now + precision, pops it and rescans
  //             (ESCAN) until nothing fires or RES_MAX expiries are out.
  // Head changed = head was the rescheduled slot, or head after differs from h0.

  state_e state_q, state_d;

  cmd_e                 cmd_q;
  logic [IW-1:0]        id_q;
  logic                 id_ok_q;
  logic [TIME_BITS-1:0] period_q;
  logic [TIME_BITS-1:0] now_q;
  logic [PREC_W-1:0]    prec_q;

  logic [NUM_TIMERS-1:0] active_q, active_d;
  logic [NUM_TIMERS-1:0] written_q, written_d;

  logic          h0_found_q;
  logic [IW-1:0] h0_idx_q;
  logic          chg_q;

  // expiry held back until we know whether it is the last result
  logic              pend_v_q;
  logic [IW-1:0]     pend_id_q;
  logic [LATE_W-1:0] pend_late_q;
  logic [NW-1:0]     cnt_q;

  // output register
  logic              out_valid_q;
  logic              ev_q;
  logic [ID_W-1:0]   eid_q;
  logic [LATE_W-1:0] late_q;
  logic              chg_out_q;
  logic              empty_q;
  logic [FIELD_W-1:0] next_q;
  logic              last_q;

  // scan unit and slot RAM
  logic                   scan_start;
  scan_stat_t             scan_stat;
  logic [IW-1:0]          scan_addr;
  logic [IW-1:0]          head_idx;
  logic [TIME_BITS-1:0]   head_end;
  logic [IW-1:0]          ram_raddr;
  logic [2*TIME_BITS-1:0] ram_rdata;
  logic [2*TIME_BITS-1:0] ram_wdata;
  logic                   ram_we;

  logic in_acc;
  logic out_free;
  logic save_h0;
  logic pop;
  logic emit_mid;
  logic emit_fin;
  logic fire;
  logic c1;
  logic differ;

  logic [TIME_BITS-1:0] rd_start;
  logic [TIME_BITS-1:0] rd_end;
  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] end_new;
  logic [LW-1:0]        late_full;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // scan owns the read port while it runs
  assign ram_raddr = scan_stat.busy ? scan_addr : id_q;
  assign rd_start  = ram_rdata[2*TIME_BITS-1:TIME_BITS];
  assign rd_end    = ram_rdata[TIME_BITS-1:0];

  // restart reuses the stored duration; never-written slot gives zero
  always_comb begin
    if (cmd_q == CMD_RESTART) begin
      dur = written_q[id_q] ? (rd_end - rd_start) : '0;
    end else begin
      dur = period_q;
    end
  end

  // end time saturates at the largest time
  assign sum       = {1'b0, now_q} + {1'b0, dur};
  assign end_new   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign ram_wdata = {now_q, end_new};
  assign ram_we    = (state_q == ST_WRITE);

  // expires when now + precision > end, no wrap
  assign fire = scan_stat.found && (cnt_q < NW'(RES_MAX)) &&
                (({1'b0, now_q} + (TIME_BITS+1)'(prec_q)) > {1'b0, head_end});
  assign late_full = LW'(now_q) - LW'(head_end);

  // rescheduled slot was the head before the request
  assign c1 = ((cmd_q == CMD_SCHEDULE) || (cmd_q == CMD_RESTART)) && id_ok_q &&
              active_q[id_q] && scan_stat.found && (head_idx == id_q);
  assign differ = (h0_found_q != scan_stat.found) ||
                  (scan_stat.found && (head_idx != h0_idx_q));

  dtq_ram #(
    .WIDTH (2*TIME_BITS),
    .DEPTH (NUM_TIMERS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (id_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dtq_scan #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .active_i   (active_q),
    .rd_end_i   (rd_end),
    .rd_addr_o  (scan_addr),
    .stat_o     (scan_stat),
    .head_idx_o (head_idx),
    .head_end_o (head_end)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    active_d   = active_q;
    written_d  = written_q;
    scan_start = 1'b0;
    save_h0    = 1'b0;
    pop        = 1'b0;
    emit_mid   = 1'b0;
    emit_fin   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          scan_start = 1'b1;
          state_d    = ST_PRE_SCAN;
        end
      end
      ST_PRE_SCAN: begin
        if (scan_stat.done) begin
          save_h0 = 1'b1;
          case (cmd_q)
            CMD_SCHEDULE, CMD_RESTART: begin
              if (id_ok_q) begin
                state_d = ST_WRITE;
              end else begin
                scan_start = 1'b1;
                state_d    = ST_POST_SCAN;
              end
            end
            CMD_CANCEL: begin
              if (id_ok_q) begin
                active_d[id_q] = 1'b0;
              end
              scan_start = 1'b1;
              state_d    = ST_POST_SCAN;
            end
            CMD_ELAPSE: begin
              state_d = scan_stat.found ? ST_JUDGE : ST_STATUS;
            end
            CMD_CLEAR: begin
              active_d   = '0;
              scan_start = 1'b1;
              state_d    = ST_POST_SCAN;
            end
            default: begin
              scan_start = 1'b1;
              state_d    = ST_POST_SCAN;
            end
          endcase
        end
      end
      ST_WRITE: begin
        active_d[id_q]  = 1'b1;
        written_d[id_q] = 1'b1;
        scan_start      = 1'b1;
        state_d         = ST_POST_SCAN;
      end
      ST_POST_SCAN: begin
        if (scan_stat.done) begin
          state_d = ST_STATUS;
        end
      end
      ST_JUDGE: begin
        if (fire) begin
          if (!pend_v_q || out_free) begin
            emit_mid           = pend_v_q;
            pop                = 1'b1;
            active_d[head_idx] = 1'b0;
            scan_start         = 1'b1;
            state_d            = ST_ESCAN;
          end
        end else begin
          state_d = ST_STATUS;
        end
      end
      ST_ESCAN: begin
        if (scan_stat.done) begin
          state_d = ST_JUDGE;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          emit_fin = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      written_q   <= '0;
      prec_q      <= '0;
      pend_v_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      written_q <= written_d;
      if (cfg_valid_i && cfg_ready_o) begin
        prec_q <= cfg_data_i;
      end
      if (in_acc) begin
        pend_v_q <= 1'b0;
        cnt_q    <= '0;
      end else if (pop) begin
        pend_v_q <= 1'b1;
        cnt_q    <= cnt_q + 1'b1;
      end
      if (emit_mid || emit_fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and working payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= cmd_e'(command_i);
      id_q     <= IW'(timer_id_i);
      id_ok_q  <= (32'(timer_id_i) < NUM_TIMERS);
      period_q <= TIME_BITS'(period_i);
      now_q    <= TIME_BITS'(time_now_i);
    end
    if (save_h0) begin
      h0_found_q <= scan_stat.found;
      h0_idx_q   <= head_idx;
      chg_q      <= c1;
    end
    if (pop) begin
      pend_id_q   <= head_idx;
      pend_late_q <= late_full[LATE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit_mid) begin
      ev_q      <= 1'b1;
      eid_q     <= ID_W'(pend_id_q);
      late_q    <= pend_late_q;
      chg_out_q <= 1'b0;
      empty_q   <= 1'b0;
      next_q    <= '0;
      last_q    <= 1'b0;
    end else if (emit_fin) begin
      ev_q      <= pend_v_q;
      eid_q     <= pend_v_q ? ID_W'(pend_id_q) : '0;
      late_q    <= pend_v_q ? pend_late_q : '0;
      chg_out_q <= chg_q || differ;
      empty_q   <= !scan_stat.found;
      next_q    <= scan_stat.found ? FIELD_W'(head_end) : '0;
      last_q    <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign expired_valid_o = ev_q;
  assign expired_id_o    = eid_q;
  assign lateness_o      = $signed(late_q);
  assign head_changed_o  = chg_out_q;
  assign queue_empty_o   = empty_q;
  assign next_deadline_o = next_q;
  assign last_o          = last_q;

endmodule

// File: rtl/dtq_checker.sv
`include "deadline_timer_queue_top_defines.svh"

module dtq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        expired_valid_o,
  input logic                        queue_empty_o,
  input logic [dtq_pkg::FIELD_W-1:0] next_deadline_o,
  input logic                        last_o
);

  import dtq_pkg::*;

  // one request in flight at a time
  `DTQ_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")
  // no new request while an expiry burst is unfinished
  `DTQ_ASSERT_NOW(a_burst_holds, out_valid_o && !last_o, !in_ready_o, "ready mid burst")
  // status-only results close their request
  `DTQ_ASSERT_NOW(a_status_last, out_valid_o && !expired_valid_o, last_o, "status result not last")
  // empty queue reports zero deadline
  `DTQ_ASSERT_NOW(a_empty_zero, out_valid_o && last_o && queue_empty_o, next_deadline_o == '0, "deadline on empty queue")
  // result held until taken
  `DTQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .expired_valid_o (expired_valid_o),
  .queue_empty_o   (queue_empty_o),
  .next_deadline_o (next_deadline_o),
  .last_o          (last_o)
);

// File: bench/tb_deadline_timer_queue_top.sv
module tb_deadline_timer_queue_top;
  import dtq_pkg::*;

  localparam int unsigned NT = NUM_TIMERS_DEF;
  // No timer slot: returned by the head search when nothing is armed.
  localparam int unsigned NO_SLOT = NT;
  // Commands past CMD_CLEAR are undefined and report status only.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [FIELD_W-1:0] TIME_MAX = '1;
  localparam logic [PREC_W-1:0] GUARD_MAX = '1;
  // Worst request: the head scan plus a rescan after each of sixteen expiries.
  localparam int unsigned END_SETTLE = 400;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned PHASE_LEN = 70;

  typedef struct {
    logic               expired_valid;
    logic [ID_W-1:0]    expired_id;
    logic [LATE_W-1:0]  lateness;
    logic               head_changed;
    logic               queue_empty;
    logic [FIELD_W-1:0] next_deadline;
    logic               last;
  } timer_result_t;

  // Mirror of the timer table plus the queue of results still owed by the block.
  class timer_queue_scoreboard;
    bit                 armed[NT];
    bit [FIELD_W-1:0]   start_at[NT];
    bit [FIELD_W-1:0]   deadline[NT];
    bit [PREC_W-1:0]    guard_time;
    timer_result_t      owed[$];
    int                 errors;

    // Earliest deadline, lowest slot on ties.
    function int unsigned earliest();
      int unsigned best;
      best = NO_SLOT;
      for (int unsigned i = 0; i < NT; i++) begin
        if (armed[i] && (best == NO_SLOT || deadline[i] < deadline[best])) best = i;
      end
      return best;
    endfunction

    function bit disarm(int unsigned id);
      bit was_head;
      if (!armed[id]) return 1'b0;
      was_head = (earliest() == id);
      armed[id] = 1'b0;
      return was_head;
    endfunction

    function bit arm(int unsigned id, bit [FIELD_W-1:0] st, bit [FIELD_W-1:0] dur);
      int unsigned prev;
      bit [FIELD_W:0] sum;
      prev = earliest();
      sum = {1'b0, st} + {1'b0, dur};
      start_at[id] = st;
      deadline[id] = sum[FIELD_W] ? TIME_MAX : sum[FIELD_W-1:0];
      armed[id] = 1'b1;
      return prev != earliest();
    endfunction

    function void owe_status(bit changed);
      timer_result_t r;
      int unsigned h;
      h = earliest();
      r.expired_valid = 1'b0;
      r.expired_id = '0;
      r.lateness = '0;
      r.head_changed = changed;
      r.queue_empty = (h == NO_SLOT);
      r.next_deadline = (h == NO_SLOT) ? '0 : deadline[h];
      r.last = 1'b1;
      owed.push_back(r);
    endfunction

    // Expiry pass: pop heads while now is past deadline minus the guard.
    function void elapse_to(bit [FIELD_W-1:0] now);
      int unsigned prev;
      int unsigned h;
      int n;
      bit [FIELD_W-1:0] e;
      bit fire;
      timer_result_t r;
      prev = earliest();
      if (prev == NO_SLOT) begin
        owe_status(1'b0);
        return;
      end
      n = 0;
      while (n < RES_MAX) begin
        h = earliest();
        if (h == NO_SLOT) break;
        e = deadline[h];
        fire = (e < guard_time) || (now > e - FIELD_W'(guard_time));
        if (!fire) break;
        armed[h] = 1'b0;
        r.expired_valid = 1'b1;
        r.expired_id = ID_W'(h);
        r.lateness = {1'b0, now} - {1'b0, e};
        r.head_changed = 1'b0;
        r.queue_empty = 1'b0;
        r.next_deadline = '0;
        r.last = 1'b0;
        owed.push_back(r);
        n++;
      end
      h = earliest();
      if (n == 0) begin
        owe_status((h == NO_SLOT) || (h != prev));
        return;
      end
      r = owed.pop_back();
      r.head_changed = (h == NO_SLOT) || (h != prev);
      r.queue_empty = (h == NO_SLOT);
      r.next_deadline = (h == NO_SLOT) ? '0 : deadline[h];
      r.last = 1'b1;
      owed.push_back(r);
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [FIELD_W-1:0] period, logic [FIELD_W-1:0] now);
      bit c1;
      bit c2;
      bit [FIELD_W-1:0] dur;
      case (cmd)
        CMD_SCHEDULE: begin
          c1 = disarm(id);
          c2 = arm(id, now, period);
          owe_status(c1 || c2);
        end
        CMD_CANCEL: begin
          owe_status(disarm(id));
        end
        CMD_RESTART: begin
          // stale times are reused on an idle slot
          dur = deadline[id] - start_at[id];
          c1 = disarm(id);
          c2 = arm(id, now, dur);
          owe_status(c1 || c2);
        end
        CMD_ELAPSE: begin
          elapse_to(now);
        end
        CMD_CLEAR: begin
          c1 = (earliest() != NO_SLOT);
          for (int unsigned i = 0; i < NT; i++) armed[i] = 1'b0;
          owe_status(c1);
        end
        default: begin
          owe_status(1'b0);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [LATE_W-1:0] want, logic [LATE_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result expected none got id %0h last %0b",
                 $time, got.expired_id, got.last);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("expired_valid", LATE_W'(want.expired_valid), LATE_W'(got.expired_valid));
      compare_field("expired_id", LATE_W'(want.expired_id), LATE_W'(got.expired_id));
      compare_field("lateness", want.lateness, got.lateness);
      compare_field("head_changed", LATE_W'(want.head_changed), LATE_W'(got.head_changed));
      compare_field("queue_empty", LATE_W'(want.queue_empty), LATE_W'(got.queue_empty));
      compare_field("next_deadline", LATE_W'(want.next_deadline), LATE_W'(got.next_deadline));
      compare_field("last", LATE_W'(want.last), LATE_W'(got.last));
    endfunction
  endclass

  // Every input starts at a known value.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [PREC_W-1:0]  cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CMD_W-1:0]   command_i = '0;
  logic [ID_W-1:0]    timer_id_i = '0;
  logic [FIELD_W-1:0] period_i = '0;
  logic [FIELD_W-1:0] time_now_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               expired_valid_o;
  logic [ID_W-1:0]    expired_id_o;
  logic signed [LATE_W-1:0] lateness_o;
  logic               head_changed_o;
  logic               queue_empty_o;
  logic [FIELD_W-1:0] next_deadline_o;
  logic               last_o;

  timer_queue_scoreboard sb;
  int unsigned        cycles = 0;
  // Set for phases that should run back to back with no sender gaps.
  bit                 steady = 1'b0;
  // Software-style clock that the well-formed traffic marches forward.
  logic [FIELD_W-1:0] sim_now;

  deadline_timer_queue_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .timer_id_i      (timer_id_i),
    .period_i        (period_i),
    .time_now_i      (time_now_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .expired_valid_o (expired_valid_o),
    .expired_id_o    (expired_id_o),
    .lateness_o      (lateness_o),
    .head_changed_o  (head_changed_o),
    .queue_empty_o   (queue_empty_o),
    .next_deadline_o (next_deadline_o),
    .last_o          (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor. Outputs are sampled at the edge, before any update lands.
  always @(posedge clk_i) begin
    timer_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.expired_valid = expired_valid_o;
      got.expired_id = expired_id_o;
      got.lateness = lateness_o;
      got.head_changed = head_changed_o;
      got.queue_empty = queue_empty_o;
      got.next_deadline = next_deadline_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Result side backpressure; now and then a long stretch of steady ready.
  initial begin
    int unsigned busy;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready_i <= 1'b1;
      busy = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 400) : $urandom_range(1, 20);
      repeat (busy) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(posedge clk_i);
      end
    end
  end

  // One request: valid goes up, holds until the block takes it, then an optional gap.
  // With no gap valid stays high and the next call only swaps the payload.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                              logic [FIELD_W-1:0] period, logic [FIELD_W-1:0] now);
    int unsigned gap;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    timer_id_i <= id;
    period_i <= period;
    time_now_i <= now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(cmd, id, period, now);
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait for every owed result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // Only ever called with the block idle.
  task automatic set_precision(logic [PREC_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.guard_time = value;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random traffic: mostly coherent timer use against a marching clock,
  // with some fully random noise requests mixed in.
  task automatic random_phase(int unsigned count, logic [FIELD_W-1:0] origin);
    int unsigned r;
    int unsigned p;
    logic [FIELD_W-1:0] dur;
    sim_now = origin;
    repeat (count) begin
      p = $urandom_range(0, 9);
      if (p < 6) dur = $urandom_range(0, 3000);
      else if (p < 8) dur = $urandom_range(0, 100000);
      else if (p < 9) dur = $urandom;
      else dur = TIME_MAX - $urandom_range(0, 50);
      r = $urandom_range(0, 99);
      if (r < 34) begin
        send_request(CMD_SCHEDULE, ID_W'($urandom_range(0, NT - 1)), dur, sim_now);
      end else if (r < 46) begin
        send_request(CMD_CANCEL, ID_W'($urandom_range(0, NT - 1)), $urandom, $urandom);
      end else if (r < 56) begin
        send_request(CMD_RESTART, ID_W'($urandom_range(0, NT - 1)), $urandom, sim_now);
      end else if (r < 87) begin
        sim_now = sim_now + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 200000)
                                                         : $urandom_range(0, 1200));
        send_request(CMD_ELAPSE, ID_W'($urandom), $urandom, sim_now);
      end else if (r < 90) begin
        send_request(CMD_CLEAR, ID_W'($urandom), $urandom, $urandom);
      end else if (r < 93) begin
        send_request(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), ID_W'($urandom),
                     $urandom, $urandom);
      end else begin
        send_request(CMD_W'($urandom), ID_W'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_precision('0);

    // Directed: empty queue, idle slots, saturation, ties, re-arm of the head.
    send_request(CMD_ELAPSE, 4'd0, 32'd0, 32'd1000);             // nothing armed
    send_request(CMD_CANCEL, 4'd3, 32'd0, 32'd0);                // idle slot
    send_request(CMD_RESTART, 4'd5, 32'd0, 32'd100);             // stale zero times
    send_request(CMD_SCHEDULE, 4'd0, TIME_MAX, TIME_MAX);        // end saturates
    send_request(CMD_SCHEDULE, 4'd15, 32'd10, 32'd50);
    send_request(CMD_SCHEDULE, 4'd7, 32'd10, 32'd50);            // tie, lower id wins
    send_request(CMD_SCHEDULE, 4'd15, 32'd5, 32'd40);            // re-schedule while armed
    send_request(CMD_ELAPSE, 4'd0, 32'd0, 32'd45);               // exactly at deadline
    send_request(CMD_ELAPSE, 4'd0, 32'd0, 32'd61);               // two pop
    send_request(CMD_RESTART, 4'd7, 32'd0, 32'd200);             // reuse stored duration
    send_request(CMD_CANCEL, 4'd5, 32'd0, 32'd0);                // drops the head
    send_request(CMD_UNUSED_LO, 4'd9, TIME_MAX, TIME_MAX);
    send_request(CMD_UNUSED_HI, 4'd15, 32'd0, 32'd0);
    send_request(CMD_SCHEDULE, 4'd2, 32'd0, 32'd0);
    send_request(CMD_ELAPSE, 4'd0, 32'd0, TIME_MAX);             // saturated one stays
    send_request(CMD_CLEAR, 4'd0, 32'd0, 32'd0);
    send_request(CMD_CLEAR, 4'd0, 32'd0, 32'd0);                 // already empty

    // Widest guard: deadlines below it fire at once, lateness goes negative.
    set_precision(GUARD_MAX);
    send_request(CMD_SCHEDULE, 4'd1, 32'd100, 32'd0);
    send_request(CMD_SCHEDULE, 4'd4, 32'd70000, 32'd0);
    send_request(CMD_ELAPSE, 4'd0, 32'd0, 32'd0);
    send_request(CMD_ELAPSE, 4'd0, 32'd0, 32'd4465);             // guard edge, no fire
    send_request(CMD_ELAPSE, 4'd0, 32'd0, 32'd4466);

    // Random phases across a spread of guard settings.
    random_phase(PHASE_LEN, $urandom_range(0, 100000));
    set_precision('0);
    random_phase(PHASE_LEN, $urandom);
    set_precision(PREC_W'($urandom_range(1, 2000)));
    steady = 1'b1;
    random_phase(PHASE_LEN, $urandom_range(0, 100000));
    steady = 1'b0;
    set_precision(PREC_W'($urandom));
    random_phase(PHASE_LEN, TIME_MAX - $urandom_range(0, 300000)); // near wraparound
    set_precision(GUARD_MAX);
    random_phase(PHASE_LEN, $urandom_range(0, 100000));

    drain();
    repeat (END_SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: deadline_timer_queue_top.f
+incdir+rtl
rtl/dtq_pkg.sv
rtl/dtq_ram.sv
rtl/dtq_scan.sv
rtl/deadline_timer_queue_top.sv
rtl/dtq_checker.sv
bench/tb_deadline_timer_queue_top.sv
